// ----- rtl/lfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line follow PID drive
// Register indexes, reset values, steer codes and the types passed between
// the top level and the PID channel.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SUM_WIDTH_DEF  = 24;
    localparam int TICK_WIDTH_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TURN  = 3'd5;

    localparam logic [15:0] GAIN_P_RST       = 16'd256;
    localparam logic [15:0] GAIN_I_RST       = 16'd26;
    localparam logic [15:0] GAIN_D_RST       = 16'd13;
    localparam int          TARGET_RST       = 1;
    localparam logic [9:0]  BASE_SPEED_RST   = 10'd300;
    localparam logic [7:0]  MIN_TURN_RST     = 8'd100;

    localparam logic [7:0]  DRIVE_MAX        = 8'd255;

    localparam logic [1:0]  STEER_FOLLOW     = 2'd0;
    localparam logic [1:0]  STEER_GENTLE     = 2'd1;
    localparam logic [1:0]  STEER_SHARP      = 2'd2;
    localparam logic [1:0]  STEER_PIVOT      = 2'd3;

    // Miss counter saturates at the pivot count.
    localparam logic [1:0]  MISS_MAX         = 2'd3;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [9:0]  base_speed;
    } lfpd_gain_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } lfpd_pipe_ctl_t;

endpackage

// ----- rtl/lfpd_sensor_if.sv -----
// ----------------------------------------------------------------------------
// lfpd_sensor_if: input channel of the line follow PID drive
// One word per control interval: both encoder counts and the line bit.
// ----------------------------------------------------------------------------
interface lfpd_sensor_if #(
    parameter int TICK_WIDTH = lfpd_pkg::TICK_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TICK_WIDTH-1:0] left_ticks;
    logic [TICK_WIDTH-1:0] right_ticks;
    logic                  line_seen;

    modport source (output valid, output left_ticks, output right_ticks,
                    output line_seen, input ready);
    modport sink   (input valid, input left_ticks, input right_ticks,
                    input line_seen, output ready);
endinterface

// ----- rtl/lfpd_drive_if.sv -----
// ----------------------------------------------------------------------------
// lfpd_drive_if: output channel of the line follow PID drive
// One word per control interval: both motor drives and the steer mode.
// ----------------------------------------------------------------------------
interface lfpd_drive_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [1:0] steer_mode;

    modport source (output valid, output left_drive, output right_drive,
                    output steer_mode, input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    input steer_mode, output ready);
endinterface

// ----- rtl/line_follow_pid_drive.sv -----
// ----------------------------------------------------------------------------
// line_follow_pid_drive: dual PID wheel speed controller with line recovery
// Two PID loops set the wheel drives; a line-lost counter slows and then
// stops the left wheel while the line is missing.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Word
// sensor    in   valid/ready    left_ticks, right_ticks, line_seen
// drive     out  valid/ready    left_drive, right_drive, steer_mode
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One word per cycle while the output is not stalled; a word passes three
// registers (error stage, gain multiply stage, result register) on its way
// to the output.
// Integral, last error and miss count update when the word is taken, so a new
// word can be taken before the last one has left the pipeline.
// A stalled output holds the pipeline; sensor.ready drops only when all
// three stages are full. Reset clears the state and reloads the configuration reset values.
// ----------------------------------------------------------------------------
module line_follow_pid_drive #(
    parameter int SUM_WIDTH  = lfpd_pkg::SUM_WIDTH_DEF,
    parameter int TICK_WIDTH = lfpd_pkg::TICK_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lfpd_sensor_if.sink                     sensor,
    lfpd_drive_if.source                    drive,
    input  logic                            cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lfpd_pkg::*;

    lfpd_gain_t            gains_reg;
    logic [TICK_WIDTH-1:0] target_reg;
    logic [7:0]            min_turn_reg;
    logic [1:0]            miss_reg;
    logic [1:0]            miss_next;
    logic [1:0]            mode_next;

    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s3_valid_reg;
    logic [1:0] mode_s1_reg;
    logic [1:0] mode_s2_reg;
    logic [7:0] left_out_reg;
    logic [7:0] right_out_reg;
    logic [1:0] mode_out_reg;

    logic           s3_free;
    logic           s2_free;
    logic           s1_free;
    logic           accept;
    lfpd_pipe_ctl_t ctl;
    logic [7:0]     left_pid;
    logic [7:0]     right_pid;
    logic [7:0]     left_next;
    logic [7:0]     left_slow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_p     <= GAIN_P_RST;
            gains_reg.gain_i     <= GAIN_I_RST;
            gains_reg.gain_d     <= GAIN_D_RST;
            gains_reg.base_speed <= BASE_SPEED_RST;
            target_reg           <= TICK_WIDTH'(TARGET_RST);
            min_turn_reg         <= MIN_TURN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:   gains_reg.gain_p     <= cfg_data;
                CFG_GAIN_I:   gains_reg.gain_i     <= cfg_data;
                CFG_GAIN_D:   gains_reg.gain_d     <= cfg_data;
                CFG_TARGET:   target_reg           <= cfg_data[TICK_WIDTH-1:0];
                CFG_BASE:     gains_reg.base_speed <= cfg_data[9:0];
                CFG_MIN_TURN: min_turn_reg         <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb
    begin
        s3_free     = !s3_valid_reg || drive.ready;
        s2_free     = !s2_valid_reg || s3_free;
        s1_free     = !s1_valid_reg || s2_free;
        accept      = sensor.valid && s1_free;
        ctl.s1_load = accept;
        ctl.s2_load = s1_valid_reg && s2_free;
    end

    assign sensor.ready = s1_free;

    always_comb
    begin
        if (sensor.line_seen)
        begin
            miss_next = '0;
            mode_next = STEER_FOLLOW;
        end
        else
        begin
            miss_next = (miss_reg == MISS_MAX) ? MISS_MAX : miss_reg + 2'd1;
            mode_next = miss_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                miss_reg <= miss_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= sensor.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    lfpd_channel #(
        .SUM_WIDTH  (SUM_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .gains  (gains_reg),
        .target (target_reg),
        .ticks  (sensor.left_ticks),
        .drive  (left_pid)
    );

    lfpd_channel #(
        .SUM_WIDTH  (SUM_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .gains  (gains_reg),
        .target (target_reg),
        .ticks  (sensor.right_ticks),
        .drive  (right_pid)
    );

    always_comb
    begin
        left_slow = '0;
        case (mode_s2_reg)
            STEER_FOLLOW:
            begin
                left_next = left_pid;
            end
            STEER_GENTLE:
            begin
                left_slow = {1'b0, left_pid[7:1]};
                left_next = (left_slow < min_turn_reg) ? min_turn_reg : left_slow;
            end
            STEER_SHARP:
            begin
                left_slow = {2'b0, left_pid[7:2]};
                left_next = (left_slow < min_turn_reg) ? min_turn_reg : left_slow;
            end
            default:
            begin
                left_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            mode_s1_reg <= mode_next;
        end
        if (ctl.s2_load)
        begin
            mode_s2_reg <= mode_s1_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            left_out_reg  <= left_next;
            right_out_reg <= right_pid;
            mode_out_reg  <= mode_s2_reg;
        end
    end

    assign drive.valid       = s3_valid_reg;
    assign drive.left_drive  = left_out_reg;
    assign drive.right_drive = right_out_reg;
    assign drive.steer_mode  = mode_out_reg;

endmodule

// ----- rtl/lfpd_channel.sv -----
// ----------------------------------------------------------------------------
// lfpd_channel: one wheel's PID speed loop
// Error, saturating integral and derivative on accept, gain products in the
// second stage, and the clamped drive from the base speed and the products.
// ----------------------------------------------------------------------------
module lfpd_channel #(
    parameter int SUM_WIDTH  = lfpd_pkg::SUM_WIDTH_DEF,
    parameter int TICK_WIDTH = lfpd_pkg::TICK_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lfpd_pkg::lfpd_pipe_ctl_t ctl,
    input  lfpd_pkg::lfpd_gain_t   gains,
    input  logic [TICK_WIDTH-1:0]  target,
    input  logic [TICK_WIDTH-1:0]  ticks,
    output logic [7:0]             drive
);
    import lfpd_pkg::*;

    localparam int E_W    = TICK_WIDTH + 1;
    localparam int D_W    = TICK_WIDTH + 2;
    localparam int SUM1_W = SUM_WIDTH + 1;
    localparam int PP_W   = E_W + 17;
    localparam int PI_W   = SUM_WIDTH + 17;
    localparam int PD_W   = D_W + 17;
    localparam int MAX_W  = (PI_W > PD_W) ? PI_W : PD_W;
    localparam int ACC_W  = MAX_W + 2;

    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [E_W-1:0]       last_reg;
    logic signed [E_W-1:0]       e_reg;
    logic signed [SUM_WIDTH-1:0] s_reg;
    logic signed [D_W-1:0]       d_reg;
    logic signed [PP_W-1:0]      pp_reg;
    logic signed [PI_W-1:0]      pi_reg;
    logic signed [PD_W-1:0]      pd_reg;

    logic signed [E_W-1:0]       e_next;
    logic signed [SUM1_W-1:0]    s_wide;
    logic signed [SUM_WIDTH-1:0] s_next;
    logic signed [D_W-1:0]       d_next;
    logic signed [16:0]          gp_s;
    logic signed [16:0]          gi_s;
    logic signed [16:0]          gd_s;
    logic signed [PP_W-1:0]      pp_next;
    logic signed [PI_W-1:0]      pi_next;
    logic signed [PD_W-1:0]      pd_next;
    logic signed [18:0]          base_s;
    logic signed [ACC_W-1:0]     acc;

    always_comb
    begin
        e_next = $signed({target[TICK_WIDTH-1], target})
               - $signed({ticks[TICK_WIDTH-1], ticks});
        s_wide = SUM1_W'(sum_reg) + SUM1_W'(e_next);
        // Overflow shows as the two top bits of the widened sum disagreeing.
        if (s_wide[SUM_WIDTH] != s_wide[SUM_WIDTH-1])
        begin
            s_next = s_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            s_next = s_wide[SUM_WIDTH-1:0];
        end
        d_next = D_W'(e_next) - D_W'(last_reg);
    end

    always_comb
    begin
        gp_s    = $signed({1'b0, gains.gain_p});
        gi_s    = $signed({1'b0, gains.gain_i});
        gd_s    = $signed({1'b0, gains.gain_d});
        pp_next = PP_W'(gp_s) * PP_W'(e_reg);
        pi_next = PI_W'(gi_s) * PI_W'(s_reg);
        pd_next = PD_W'(gd_s) * PD_W'(d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            last_reg <= '0;
        end
        else if (ctl.s1_load)
        begin
            sum_reg  <= s_next;
            last_reg <= e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            e_reg <= e_next;
            s_reg <= s_next;
            d_reg <= d_next;
        end
        if (ctl.s2_load)
        begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
    end

    always_comb
    begin
        base_s = $signed({1'b0, gains.base_speed, 8'b0});
        acc    = ACC_W'(base_s) + ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
        // Below one whole unit, negative sums included, the drive is zero.
        if (acc[ACC_W-1] || (acc[ACC_W-2:8] == '0))
        begin
            drive = '0;
        end
        else if (acc[ACC_W-2:16] != '0)
        begin
            drive = DRIVE_MAX;
        end
        else
        begin
            drive = acc[15:8];
        end
    end

endmodule

// ----- rtl/lfpd_checker.sv -----
// ----------------------------------------------------------------------------
// lfpd_checker: port-level checks for the line follow PID drive
// Tracks words in flight from the two handshakes and checks occupancy,
// output hold and the pivot drive.
// ----------------------------------------------------------------------------
module lfpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] left_drive,
    input logic [7:0] right_drive,
    input logic [1:0] steer_mode
);
    import lfpd_pkg::*;

    logic [2:0] inflight_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            inflight_reg <= inflight_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_reg <= inflight_reg - 3'd1;
        end
    end

    // The pipeline holds at most three words.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd3)
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("output word without a matching input word");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 3'd0 |-> in_ready)
        else $error("empty block refuses input");

    a_pivot_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && steer_mode == STEER_PIVOT |-> left_drive == 8'd0)
        else $error("left drive not stopped in pivot");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_drive)
            && $stable(right_drive) && $stable(steer_mode))
        else $error("stalled output word changed");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sensor.valid),
    .in_ready    (sensor.ready),
    .out_valid   (drive.valid),
    .out_ready   (drive.ready),
    .left_drive  (drive.left_drive),
    .right_drive (drive.right_drive),
    .steer_mode  (drive.steer_mode)
);
